/* sv/cams_pkg.sv */
// Package for the CPU addressing-mode sequencer: word types and code constants.
// No dependencies; used by cpu_addressing_mode_sequencer.
package cams_pkg;

  // Operation codes on the input word
  localparam logic [1:0] OP_LOAD_PC = 2'd0;
  localparam logic [1:0] OP_BEGIN   = 2'd1;
  localparam logic [1:0] OP_CYCLE   = 2'd2;

  // Addressing modes
  localparam logic [3:0] MODE_UNKNOWN = 4'd0;
  localparam logic [3:0] MODE_ACC     = 4'd1;
  localparam logic [3:0] MODE_IMPL    = 4'd2;
  localparam logic [3:0] MODE_IMM     = 4'd3;
  localparam logic [3:0] MODE_ZP      = 4'd4;
  localparam logic [3:0] MODE_ZPX     = 4'd5;
  localparam logic [3:0] MODE_ZPY     = 4'd6;
  localparam logic [3:0] MODE_REL     = 4'd7;
  localparam logic [3:0] MODE_ABS     = 4'd8;
  localparam logic [3:0] MODE_ABSX    = 4'd9;
  localparam logic [3:0] MODE_ABSY    = 4'd10;
  localparam logic [3:0] MODE_IND     = 4'd11;
  localparam logic [3:0] MODE_INDX    = 4'd12;
  localparam logic [3:0] MODE_INDY    = 4'd13;

  // Access kinds
  localparam logic [1:0] ACC_READ  = 2'd0;
  localparam logic [1:0] ACC_WRITE = 2'd1;
  localparam logic [1:0] ACC_RMW   = 2'd2;
  localparam logic [1:0] ACC_UNDEF = 2'd3;

  // Address constants
  localparam logic [15:0] PAGE_INC = 16'h0100;
  localparam logic [15:0] PAGE_DEC = 16'hFF00;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  mode;
    logic [1:0]  access_kind;
    logic        is_jump_absolute;
    logic [15:0] new_pc;
    logic [7:0]  read_data;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  accumulator;
    logic [7:0]  exec_result;
    logic        branch_taken;
  } in_word_t;

  typedef struct packed {
    logic [15:0] bus_address;
    logic        bus_read;
    logic        bus_write;
    logic [7:0]  write_data;
    logic        execute_strobe;
    logic [7:0]  operand_value;
    logic        poll_interrupts;
    logic        finished;
    logic [15:0] pc_out;
    logic        page_crossed_out;
  } out_word_t;

endpackage

/* sv/cpu_addressing_mode_sequencer.sv */
// Top level of the CPU addressing-mode sequencer: input register, step
// logic and result register. Depends on cams_pkg.
//
// Usage:
//   The input channel (in_valid_i/in_ready_o/in_data_i) carries one word per
//   CPU bus cycle: load program counter, begin instruction, or one bus cycle
//   carrying the byte read for the previous request. The output channel
//   (out_valid_o/out_ready_i/out_data_o) returns one word for each begin and
//   each bus cycle; a load-pc word or op code three gives no output word.
//   A word accepted into the input register is stepped into the result
//   register once that is free. Throughput: one word per cycle while the
//   receiver does not stall; the step logic between the input register and
//   the result register handles a whole bus cycle.
//   When the receiver stalls, the result register holds its word and the
//   input register holds the next one; in_ready_o drops only when both are
//   full and out_ready_i is low.
//   Reset (rst_ni low) empties both registers and clears the program
//   counter, address latches, data latch, page flag and step counter, so
//   the sequencer starts idle.
module cpu_addressing_mode_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cams_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cams_pkg::out_word_t  out_data_o
);

  // Handshake registers
  logic                in_valid_q;
  cams_pkg::in_word_t  in_q;
  logic                out_valid_q;
  cams_pkg::out_word_t out_q;
  logic                out_free;
  logic                proc;

  // Sequencer state
  logic [15:0] pc_q, pc_d;
  logic [15:0] ea_q, ea_d;
  logic [15:0] pa_q, pa_d;
  logic [7:0]  dl_q, dl_d;
  logic        page_q, page_d;
  logic [2:0]  step_q, step_d;
  logic [3:0]  mode_q, mode_d;
  logic [1:0]  access_q, access_d;
  logic        jump_q, jump_d;

  // Step results
  cams_pkg::out_word_t res;
  logic                has_res;
  logic [2:0]          nstep;
  logic                tail_en;
  logic [2:0]          tail_t;

  assign out_free   = !out_valid_q || out_ready_i;
  assign proc       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && has_res) begin
      out_q <= res;
    end
  end

  // Sequencer state, committed when a word is stepped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      ea_q     <= '0;
      pa_q     <= '0;
      dl_q     <= '0;
      page_q   <= 1'b0;
      step_q   <= '0;
      mode_q   <= '0;
      access_q <= '0;
      jump_q   <= 1'b0;
    end else if (proc) begin
      pc_q     <= pc_d;
      ea_q     <= ea_d;
      pa_q     <= pa_d;
      dl_q     <= dl_d;
      page_q   <= page_d;
      step_q   <= step_d;
      mode_q   <= mode_d;
      access_q <= access_d;
      jump_q   <= jump_d;
    end
  end

  // One bus cycle of the addressing sequence
  always_comb begin
    logic [8:0] sum9;
    logic [7:0] idx;
    logic [7:0] lo;
    logic [7:0] nl;

    pc_d     = pc_q;
    ea_d     = ea_q;
    pa_d     = pa_q;
    dl_d     = dl_q;
    page_d   = page_q;
    step_d   = step_q;
    mode_d   = mode_q;
    access_d = access_q;
    jump_d   = jump_q;
    res      = '0;
    has_res  = 1'b0;
    nstep    = step_q + 3'd1;
    tail_en  = 1'b0;
    tail_t   = 3'd0;
    sum9     = '0;
    idx      = (mode_q == cams_pkg::MODE_ABSX || mode_q == cams_pkg::MODE_ZPX)
               ? in_q.index_x : in_q.index_y;
    lo       = pc_q[7:0];
    nl       = pc_q[7:0] + dl_q;

    unique case (in_q.op)
      cams_pkg::OP_LOAD_PC: begin
        pc_d   = in_q.new_pc;
        step_d = 3'd0;
      end
      cams_pkg::OP_BEGIN: begin
        has_res  = 1'b1;
        mode_d   = in_q.mode;
        access_d = (in_q.access_kind == cams_pkg::ACC_UNDEF) ? cams_pkg::ACC_READ
                                                            : in_q.access_kind;
        jump_d   = in_q.is_jump_absolute;
        page_d   = 1'b0;
        step_d   = 3'd1;
        res.bus_address = pc_q;
        res.bus_read    = 1'b1;
      end
      cams_pkg::OP_CYCLE: begin
        has_res = 1'b1;
        if (step_q != 3'd0) begin
          unique case (mode_q) inside
            cams_pkg::MODE_ACC: begin
              res.execute_strobe  = 1'b1;
              res.operand_value   = in_q.accumulator;
              res.poll_interrupts = 1'b1;
              res.finished        = 1'b1;
              nstep               = 3'd0;
            end
            cams_pkg::MODE_IMPL: begin
              res.execute_strobe = 1'b1;
              nstep              = step_q;
            end
            cams_pkg::MODE_IMM: begin
              dl_d                = in_q.read_data;
              pc_d                = pc_q + 16'd1;
              res.execute_strobe  = 1'b1;
              res.operand_value   = in_q.read_data;
              res.poll_interrupts = 1'b1;
              res.finished        = 1'b1;
              nstep               = 3'd0;
            end
            cams_pkg::MODE_ZP: begin
              if (step_q == 3'd1) begin
                ea_d = {8'h00, in_q.read_data};
                pc_d = pc_q + 16'd1;
                if (access_q != cams_pkg::ACC_WRITE) begin
                  res.bus_address = ea_d;
                  res.bus_read    = 1'b1;
                end
              end else begin
                tail_en = 1'b1;
                tail_t  = 3'd2;
              end
            end
            cams_pkg::MODE_ZPX, cams_pkg::MODE_ZPY: begin
              if (step_q == 3'd1) begin
                ea_d = {8'h00, in_q.read_data};
                pc_d = pc_q + 16'd1;
                res.bus_address = ea_d;
                res.bus_read    = 1'b1;
              end else if (step_q == 3'd2) begin
                dl_d = in_q.read_data;
                ea_d = {8'h00, ea_q[7:0] + idx};
                if (access_q != cams_pkg::ACC_WRITE) begin
                  res.bus_address = ea_d;
                  res.bus_read    = 1'b1;
                end
              end else begin
                tail_en = 1'b1;
                tail_t  = 3'd3;
              end
            end
            cams_pkg::MODE_REL: begin
              if (step_q == 3'd1) begin
                dl_d                = in_q.read_data;
                pc_d                = pc_q + 16'd1;
                res.execute_strobe  = 1'b1;
                res.operand_value   = in_q.read_data;
                res.poll_interrupts = 1'b1;
                if (!in_q.branch_taken) begin
                  res.finished = 1'b1;
                  nstep        = 3'd0;
                end
              end else if (step_q == 3'd2) begin
                // Low-byte add; the high byte is fixed up in a further step on a page cross
                pc_d   = {pc_q[15:8], nl};
                page_d = dl_q[7] ? (nl > lo) : (nl < lo);
                if (!page_d) begin
                  res.finished = 1'b1;
                  nstep        = 3'd0;
                end
              end else if (step_q == 3'd3) begin
                res.poll_interrupts = 1'b1;
                pc_d = pc_q + (dl_q[7] ? cams_pkg::PAGE_DEC : cams_pkg::PAGE_INC);
                res.finished = 1'b1;
                nstep        = 3'd0;
              end else begin
                res.finished = 1'b1;
                nstep        = 3'd0;
              end
            end
            cams_pkg::MODE_ABS: begin
              if (step_q == 3'd1) begin
                ea_d = {8'h00, in_q.read_data};
                pc_d = pc_q + 16'd1;
                res.bus_address = pc_d;
                res.bus_read    = 1'b1;
              end else if (step_q == 3'd2) begin
                ea_d = {in_q.read_data, ea_q[7:0]};
                if (jump_q) begin
                  res.poll_interrupts = 1'b1;
                  pc_d         = ea_d;
                  res.finished = 1'b1;
                  nstep        = 3'd0;
                end else begin
                  pc_d = pc_q + 16'd1;
                  if (access_q != cams_pkg::ACC_WRITE) begin
                    res.bus_address = ea_d;
                    res.bus_read    = 1'b1;
                  end
                end
              end else begin
                tail_en = 1'b1;
                tail_t  = 3'd3;
              end
            end
            cams_pkg::MODE_ABSX, cams_pkg::MODE_ABSY, cams_pkg::MODE_INDY: begin
              if (step_q == 3'd1) begin
                if (mode_q == cams_pkg::MODE_INDY) begin
                  pa_d = {8'h00, in_q.read_data};
                  pc_d = pc_q + 16'd1;
                  res.bus_address = pa_d;
                end else begin
                  ea_d = {8'h00, in_q.read_data};
                  pc_d = pc_q + 16'd1;
                  res.bus_address = pc_d;
                end
                res.bus_read = 1'b1;
              end else if (step_q == 3'd2 && mode_q == cams_pkg::MODE_INDY) begin
                // Pointer high byte read wraps within zero page
                ea_d = {8'h00, in_q.read_data};
                pa_d = {8'h00, pa_q[7:0] + 8'd1};
                res.bus_address = pa_d;
                res.bus_read    = 1'b1;
              end else if ((step_q == 3'd2 && mode_q != cams_pkg::MODE_INDY) ||
                           (step_q == 3'd3 && mode_q == cams_pkg::MODE_INDY)) begin
                // Index add on the low byte; carry marks a page cross
                sum9   = {1'b0, ea_q[7:0]} + {1'b0, idx};
                page_d = sum9[8];
                ea_d   = {in_q.read_data, sum9[7:0]};
                if (mode_q != cams_pkg::MODE_INDY) begin
                  pc_d = pc_q + 16'd1;
                end
                res.bus_address = ea_d;
                res.bus_read    = 1'b1;
              end else if ((step_q == 3'd3 && mode_q != cams_pkg::MODE_INDY) ||
                           (step_q == 3'd4 && mode_q == cams_pkg::MODE_INDY)) begin
                dl_d = in_q.read_data;
                if (access_q == cams_pkg::ACC_READ && !page_q) begin
                  res.execute_strobe  = 1'b1;
                  res.operand_value   = in_q.read_data;
                  res.poll_interrupts = 1'b1;
                  res.finished        = 1'b1;
                  nstep               = 3'd0;
                end else begin
                  if (page_q) begin
                    ea_d = ea_q + cams_pkg::PAGE_INC;
                  end
                  if (access_q != cams_pkg::ACC_WRITE) begin
                    res.bus_address = ea_d;
                    res.bus_read    = 1'b1;
                  end
                end
              end else begin
                tail_en = 1'b1;
                tail_t  = (mode_q == cams_pkg::MODE_INDY) ? 3'd5 : 3'd4;
              end
            end
            cams_pkg::MODE_IND: begin
              if (step_q == 3'd1) begin
                pa_d = {8'h00, in_q.read_data};
                pc_d = pc_q + 16'd1;
                res.bus_address = pc_d;
                res.bus_read    = 1'b1;
              end else if (step_q == 3'd2) begin
                pa_d = {in_q.read_data, pa_q[7:0]};
                pc_d = pc_q + 16'd1;
                res.bus_address = pa_d;
                res.bus_read    = 1'b1;
              end else if (step_q == 3'd3) begin
                // Second pointer byte stays in the same page
                dl_d = in_q.read_data;
                pa_d = {pa_q[15:8], pa_q[7:0] + 8'd1};
                res.bus_address = pa_d;
                res.bus_read    = 1'b1;
              end else if (step_q == 3'd4) begin
                res.poll_interrupts = 1'b1;
                pc_d         = {in_q.read_data, dl_q};
                res.finished = 1'b1;
                nstep        = 3'd0;
              end else begin
                res.finished = 1'b1;
                nstep        = 3'd0;
              end
            end
            cams_pkg::MODE_INDX: begin
              if (step_q == 3'd1) begin
                pa_d = {8'h00, in_q.read_data};
                pc_d = pc_q + 16'd1;
                res.bus_address = pa_d;
                res.bus_read    = 1'b1;
              end else if (step_q == 3'd2) begin
                dl_d = in_q.read_data;
                pa_d = {8'h00, pa_q[7:0] + in_q.index_x};
                res.bus_address = pa_d;
                res.bus_read    = 1'b1;
              end else if (step_q == 3'd3) begin
                ea_d = {8'h00, in_q.read_data};
                pa_d = {8'h00, pa_q[7:0] + 8'd1};
                res.bus_address = pa_d;
                res.bus_read    = 1'b1;
              end else if (step_q == 3'd4) begin
                ea_d = {in_q.read_data, ea_q[7:0]};
                if (access_q != cams_pkg::ACC_WRITE) begin
                  res.bus_address = ea_d;
                  res.bus_read    = 1'b1;
                end
              end else begin
                tail_en = 1'b1;
                tail_t  = 3'd5;
              end
            end
            default: begin
              // Unknown modes finish at once without bus access
              res.finished = 1'b1;
              nstep        = 3'd0;
            end
          endcase

          // Operand cycle (a write stores there), then dummy write and final write for RMW
          if (tail_en) begin
            if (step_q == tail_t) begin
              if (access_q != cams_pkg::ACC_WRITE) begin
                dl_d = in_q.read_data;
              end
              if (access_q == cams_pkg::ACC_READ) begin
                res.execute_strobe  = 1'b1;
                res.operand_value   = in_q.read_data;
                res.poll_interrupts = 1'b1;
                res.finished        = 1'b1;
                nstep               = 3'd0;
              end else if (access_q == cams_pkg::ACC_WRITE) begin
                res.execute_strobe  = 1'b1;
                res.poll_interrupts = 1'b1;
                res.bus_address     = ea_q;
                res.bus_write       = 1'b1;
                res.write_data      = in_q.exec_result;
                res.finished        = 1'b1;
                nstep               = 3'd0;
              end
            end else if ({1'b0, step_q} == {1'b0, tail_t} + 4'd1) begin
              res.bus_address    = ea_q;
              res.bus_write      = 1'b1;
              res.write_data     = dl_q;
              res.execute_strobe = 1'b1;
              res.operand_value  = dl_q;
            end else if ({1'b0, step_q} == {1'b0, tail_t} + 4'd2) begin
              res.poll_interrupts = 1'b1;
              res.bus_address     = ea_q;
              res.bus_write       = 1'b1;
              res.write_data      = in_q.exec_result;
              res.finished        = 1'b1;
              nstep               = 3'd0;
            end else begin
              res.finished = 1'b1;
              nstep        = 3'd0;
            end
          end
          step_d = nstep;
        end
      end
      default: ;
    endcase

    res.pc_out           = pc_d;
    res.page_crossed_out = page_d;
  end

  // Checks on the step logic
  a_no_read_and_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.bus_read && out_data_o.bus_write))
    else $error("read and write requested in the same word");

  a_wdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.bus_write |-> out_data_o.write_data == 8'h00)
    else $error("write data set without a write");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.bus_read && !out_data_o.bus_write
      |-> out_data_o.bus_address == 16'h0000)
    else $error("address driven without an access");

  a_finish_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && has_res && res.finished |=> step_q == 3'd0)
    else $error("step counter not idle after finish");

  a_idle_cycle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_q.op == cams_pkg::OP_CYCLE && step_q == 3'd0
      |=> out_valid_q && !out_q.finished && !out_q.bus_read && !out_q.execute_strobe)
    else $error("activity on a bus cycle while idle");

endmodule
